### rtl/sli_pkg.sv
// Shared types, codes and defaults for the sorted insertion list.
`default_nettype none

package sli_pkg;

    localparam int DEPTH_DEF = 64;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] value;
        logic        [7:0]  position;
    } t_req;

    typedef struct packed {
        logic        [1:0]  status;
        logic        [6:0]  entry_count;
        logic signed [31:0] smallest;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_FIN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic ins_rd;
        logic ins_wr;
        logic del_rd;
        logic del_wr;
        logic fin;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic load_del;
        logic load_fail;
        logic ptr_zero;
        logic rd_ge;
        logic del_end;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### rtl/sli_if.sv
// Valid/ready channel interfaces for request and response words.
`default_nettype none

interface sli_req_if;
    import sli_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sli_rsp_if;
    import sli_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/sli_ctrl.sv
// Sequencer for insert and delete: walks the list one entry per read/write pair.
`default_nettype none

module sli_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    input  wire sli_pkg::t_sts i_sts,
    output logic               o_req_ready,
    output sli_pkg::t_cmd      o_cmd
);
    import sli_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_sts.load_fail) n_state = S_FIN;
                    else if (i_sts.load_del) n_state = S_DEL_RD;
                    else n_state = S_INS_RD;
                end
            end
            S_INS_RD: n_state = i_sts.ptr_zero ? S_FIN : S_INS_WR;
            S_INS_WR: n_state = i_sts.rd_ge ? S_INS_RD : S_FIN;
            S_DEL_RD: n_state = i_sts.del_end ? S_FIN : S_DEL_WR;
            S_DEL_WR: n_state = S_DEL_RD;
            S_FIN:    n_state = i_sts.out_free ? S_IDLE : S_FIN;
            default:  n_state = S_IDLE;
        endcase
    end

    // no request is taken while reset is held
    always_comb begin
        o_cmd        = '0;
        o_req_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = i_rst_n;
                o_cmd.load  = i_req_valid && i_rst_n;
            end
            S_INS_RD: o_cmd.ins_rd = 1'b1;
            S_INS_WR: o_cmd.ins_wr = 1'b1;
            S_DEL_RD: o_cmd.del_rd = 1'b1;
            S_DEL_WR: o_cmd.del_wr = 1'b1;
            S_FIN:    o_cmd.fin    = 1'b1;
            default: begin
                o_cmd       = '0;
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/sli_dpath.sv
// Datapath: value memory, count, head copy, walk pointer and response register.
`default_nettype none

module sli_dpath #(
    parameter int DEPTH = sli_pkg::DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sli_pkg::t_cmd i_cmd,
    input  wire sli_pkg::t_req i_req,
    input  wire logic          i_rsp_ready,
    output sli_pkg::t_sts      o_sts,
    output logic               o_rsp_valid,
    output sli_pkg::t_rsp      o_rsp
);
    import sli_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic        [31:0]   r_mem [DEPTH];
    logic signed [31:0]   r_rd;
    logic        [CW-1:0] r_count;
    logic        [CW-1:0] n_count;
    logic        [IW-1:0] r_ptr;
    logic        [IW-1:0] n_ptr;
    logic signed [31:0]   r_val;
    logic signed [31:0]   n_val;
    logic        [1:0]    r_status;
    logic        [1:0]    n_status;
    logic signed [31:0]   r_head;
    logic signed [31:0]   n_head;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_rsp                 r_out;
    t_rsp                 n_out;

    logic                 we;
    logic        [IW-1:0] waddr;
    logic        [31:0]   wdata;
    logic        [IW-1:0] raddr;
    logic        [1:0]    load_status;
    logic                 full;
    logic                 empty;
    logic                 out_free;

    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);
    assign out_free = !r_out_valid || i_rsp_ready;

    always_comb begin
        if (i_req.opcode == OP_INSERT) begin
            load_status = full ? ST_FULL : ST_OK;
        end else if (empty) begin
            load_status = ST_EMPTY;
        end else if (i_req.position == 8'd0 || {1'b0, i_req.position} > 9'(r_count)) begin
            load_status = ST_BADPOS;
        end else begin
            load_status = ST_OK;
        end
    end

    assign o_sts.load_del  = (i_req.opcode == OP_DELETE);
    assign o_sts.load_fail = (load_status != ST_OK);
    assign o_sts.ptr_zero  = (r_ptr == '0);
    assign o_sts.rd_ge     = (r_rd >= r_val);
    assign o_sts.del_end   = ((CW'(r_ptr) + CW'(1)) >= r_count);
    assign o_sts.out_free  = out_free;

    always_comb begin
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_val    = r_val;
        n_status = r_status;
        we       = 1'b0;
        waddr    = r_ptr;
        wdata    = r_val;
        raddr    = r_ptr;
        if (i_cmd.load) begin
            n_val    = i_req.value;
            n_status = load_status;
            n_ptr    = (i_req.opcode == OP_DELETE) ? IW'(i_req.position - 8'd1)
                                                   : IW'(r_count);
        end
        // insert walks down from the top, shifting up every entry >= value
        if (i_cmd.ins_rd) begin
            if (r_ptr == '0) begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = r_val;
                n_count = r_count + CW'(1);
            end else begin
                raddr = r_ptr - IW'(1);
            end
        end
        if (i_cmd.ins_wr) begin
            we = 1'b1;
            if (r_rd >= r_val) begin
                wdata = r_rd;
                n_ptr = r_ptr - IW'(1);
            end else begin
                wdata   = r_val;
                n_count = r_count + CW'(1);
            end
        end
        // delete walks up, pulling each following entry down one place
        if (i_cmd.del_rd) begin
            if ((CW'(r_ptr) + CW'(1)) >= r_count) begin
                n_count = r_count - CW'(1);
            end else begin
                raddr = r_ptr + IW'(1);
            end
        end
        if (i_cmd.del_wr) begin
            we    = 1'b1;
            wdata = r_rd;
            n_ptr = r_ptr + IW'(1);
        end
    end

    assign n_head = (we && waddr == '0) ? $signed(wdata) : r_head;

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (i_rsp_ready) n_out_valid = 1'b0;
        if (i_cmd.fin && out_free) begin
            n_out_valid       = 1'b1;
            n_out.status      = r_status;
            n_out.entry_count = 7'(r_count);
            n_out.smallest    = empty ? 32'sd0 : r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rd <= $signed(r_mem[raddr]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_val    <= n_val;
        r_status <= n_status;
        r_head   <= n_head;
        r_out    <= n_out;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

`default_nettype wire

### rtl/sorted_list_insert_delete_core.sv
// Sorted insertion list: up to DEPTH signed words kept in ascending order.
// Request channel i_req carries opcode (insert/delete), value and a one-based
// delete position; response channel o_rsp returns one word per request with
// status, entry_count and smallest (zero when the list is empty).
// Requests are taken one at a time. The list lives in a memory with one read
// and one write port, so each entry moved costs one read and one write.
// An insert walks down from the top and moves every stored entry >= the new
// value up one place; a delete walks up and moves every entry above the
// deleted position down one place. A refused access (full, empty, bad
// position) moves no entry and goes straight to the response.
// The response sits in an output register; a new request is accepted while
// it waits, and that request's response is held back until the old word has
// been taken. A stalled receiver therefore stalls at most one request deep.
// Reset (synchronous, active low) holds request ready low, empties the list
// and drops any pending response; the memory is not cleared and need not be,
// since only entries below the count are ever used.
`default_nettype none

module sorted_list_insert_delete_core #(
    parameter int DEPTH = sli_pkg::DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sli_req_if.sink    i_req,
    sli_rsp_if.source  o_rsp
);
    import sli_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic req_ready;
    logic rsp_valid;
    t_rsp rsp;

    sli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (sts),
        .o_req_ready (req_ready),
        .o_cmd       (cmd)
    );

    sli_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req.data),
        .i_rsp_ready (o_rsp.ready),
        .o_sts       (sts),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp)
    );

    assign i_req.ready = req_ready;
    assign o_rsp.valid = rsp_valid;
    assign o_rsp.data  = rsp;

endmodule

`default_nettype wire

### rtl/sli_checker.sv
// Port-level checks for the sorted insertion list, bound to the top level.
`default_nettype none

module sli_checker #(
    parameter int DEPTH = sli_pkg::DEPTH_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic [1:0]  i_rsp_status,
    input wire logic [6:0]  i_rsp_count,
    input wire logic [31:0] i_rsp_smallest
);
    import sli_pkg::*;

    // a response word must hold steady until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid
            && $stable({i_rsp_status, i_rsp_count, i_rsp_smallest}))
        else $error("response word changed or dropped while stalled");

    a_rst_drop: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_FULL |-> i_rsp_count == 7'(DEPTH))
        else $error("full status with count below depth");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_EMPTY
            |-> i_rsp_count == 7'd0 && i_rsp_smallest == 32'd0)
        else $error("empty status with entries reported");

endmodule

bind sorted_list_insert_delete_core sli_checker #(
    .DEPTH (DEPTH)
) u_sli_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_status   (o_rsp.data.status),
    .i_rsp_count    (o_rsp.data.entry_count),
    .i_rsp_smallest (o_rsp.data.smallest)
);

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the sorted insertion list core.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sli_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int N_RANDOM     = 1600;
    localparam int QUIET_TAIL   = 200;
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;
    localparam int LIMIT_CYCLES = 1_200_000;
    localparam int N_ROWS       = 23;

    typedef struct {
        logic               op;
        logic signed [31:0] val;
        logic        [7:0]  pos;
        bit                 typed;
        logic        [1:0]  st;
        logic        [6:0]  cnt;
        logic signed [31:0] sml;
    } t_row;

    // Hand-checked rows carry typed=1; the rest go through the list model.
    t_row dir_rows [N_ROWS] = '{
        '{OP_DELETE, 32'sd0,           8'd0,   1'b1, ST_EMPTY,  7'd0, 32'sd0},
        '{OP_DELETE, 32'sd0,           8'd255, 1'b1, ST_EMPTY,  7'd0, 32'sd0},
        '{OP_DELETE, 32'sd0,           8'd1,   1'b1, ST_EMPTY,  7'd0, 32'sd0},
        '{OP_INSERT, 32'sd0,           8'd0,   1'b1, ST_OK,     7'd1, 32'sd0},
        '{OP_DELETE, 32'sd0,           8'd2,   1'b1, ST_BADPOS, 7'd1, 32'sd0},
        '{OP_DELETE, 32'sd0,           8'd0,   1'b1, ST_BADPOS, 7'd1, 32'sd0},
        '{OP_DELETE, 32'sd0,           8'd1,   1'b1, ST_OK,     7'd0, 32'sd0},
        '{OP_INSERT, 32'sh7FFF_FFFF,   8'd0,   1'b1, ST_OK,     7'd1, 32'sh7FFF_FFFF},
        '{OP_INSERT, 32'sh8000_0000,   8'd255, 1'b1, ST_OK,     7'd2, 32'sh8000_0000},
        '{OP_INSERT, -32'sd1,          8'd0,   1'b0, ST_OK,     7'd0, 32'sd0},
        '{OP_INSERT, 32'sd0,           8'd0,   1'b0, ST_OK,     7'd0, 32'sd0},
        '{OP_INSERT, 32'sd0,           8'd0,   1'b0, ST_OK,     7'd0, 32'sd0},
        '{OP_INSERT, 32'sh7FFF_FFFF,   8'd0,   1'b0, ST_OK,     7'd0, 32'sd0},
        '{OP_INSERT, 32'sh8000_0000,   8'd0,   1'b0, ST_OK,     7'd0, 32'sd0},
        '{OP_DELETE, 32'sd0,           8'd255, 1'b0, ST_OK,     7'd0, 32'sd0},
        '{OP_DELETE, 32'sd0,           8'd8,   1'b0, ST_OK,     7'd0, 32'sd0},
        '{OP_DELETE, 32'sd0,           8'd7,   1'b0, ST_OK,     7'd0, 32'sd0},
        '{OP_DELETE, 32'sd0,           8'd1,   1'b0, ST_OK,     7'd0, 32'sd0},
        '{OP_DELETE, 32'sd0,           8'd3,   1'b0, ST_OK,     7'd0, 32'sd0},
        '{OP_INSERT, 32'sh5555_5555,   8'd0,   1'b0, ST_OK,     7'd0, 32'sd0},
        '{OP_INSERT, 32'shAAAA_AAAA,   8'd0,   1'b0, ST_OK,     7'd0, 32'sd0},
        '{OP_DELETE, 32'sd0,           8'd128, 1'b0, ST_OK,     7'd0, 32'sd0},
        '{OP_DELETE, 32'sd0,           8'd1,   1'b0, ST_OK,     7'd0, 32'sd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sli_req_if req_if ();
    sli_rsp_if rsp_if ();

    sorted_list_insert_delete_core #(
        .DEPTH (LIST_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #10 i_clk = ~i_clk;

    logic signed [31:0] list_q [$];
    t_rsp               rsp_due_q [$];
    bit                 idle_ok = 1'b1;
    int                 err_cnt = 0;
    int                 cycle_cnt = 0;
    int                 n_ins = 0, n_del = 0, n_full = 0, n_empty = 0, n_badpos = 0;
    int                 peak_fill = 0;

    // Apply one word to the shadow list and return the response it should give.
    function automatic t_rsp list_apply(input t_req w);
        t_rsp               r;
        int                 slot;
        int                 i;
        logic signed [31:0] v;
        v = w.value;
        r.status = ST_OK;
        if (w.opcode == OP_INSERT) begin
            n_ins++;
            if (list_q.size() >= LIST_DEPTH) begin
                r.status = ST_FULL;
                n_full++;
            end else begin
                // equal values go in front, so newest duplicate comes first
                slot = list_q.size();
                for (i = 0; i < list_q.size(); i++) begin
                    if (list_q[i] >= v) begin
                        slot = i;
                        break;
                    end
                end
                list_q.insert(slot, v);
            end
        end else begin
            n_del++;
            if (list_q.size() == 0) begin
                r.status = ST_EMPTY;
                n_empty++;
            end else if (w.position == 8'd0 || int'(w.position) > list_q.size()) begin
                r.status = ST_BADPOS;
                n_badpos++;
            end else begin
                list_q.delete(int'(w.position) - 1);
            end
        end
        if (list_q.size() > peak_fill)
            peak_fill = list_q.size();
        r.entry_count = 7'(list_q.size());
        r.smallest    = (list_q.size() > 0) ? list_q[0] : 32'sd0;
        return r;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0, 1: return $urandom;
            2, 3: return 32'($urandom_range(0, 16)) - 32'd8;
            4: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return 32'($urandom_range(0, 2000)) - 32'd1000;
        endcase
    endfunction

    function automatic logic [7:0] pick_position();
        int n;
        n = list_q.size();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'($urandom_range(n + 1, 255));
            2: return 8'($urandom_range(0, 255));
            default: return (n == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, n));
        endcase
    endfunction

    // Present one word, hold it until taken, then log what it should produce.
    task automatic send_word(input t_req w, input bit typed, input t_rsp typed_rsp);
        t_rsp pred;
        if (idle_ok && $urandom_range(0, 3) == 0) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.data  = w;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        pred = list_apply(w);
        rsp_due_q.push_back(typed ? typed_rsp : pred);
        @(negedge i_clk);
    endtask

    initial begin : reset_seq
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    initial begin : rsp_stall
        int stall;
        stall = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                rsp_if.ready = 1'b0;
                stall--;
            end else if (idle_ok && $urandom_range(0, 7) == 0) begin
                rsp_if.ready = 1'b0;
                stall = $urandom_range(1, 15) - 1;
            end else begin
                rsp_if.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (rsp_due_q.size() == 0) begin
                $display("%0t: response word with nothing expected: %p", $time, rsp_if.data);
                err_cnt++;
            end else begin
                want = rsp_due_q.pop_front();
                if (rsp_if.data.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, rsp_if.data.status);
                    err_cnt++;
                end
                if (rsp_if.data.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d got %0d",
                             $time, want.entry_count, rsp_if.data.entry_count);
                    err_cnt++;
                end
                if (rsp_if.data.smallest !== want.smallest) begin
                    $display("%0t: smallest expected %0d got %0d",
                             $time, want.smallest, rsp_if.data.smallest);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("%0t: timed out after %0d cycles, %0d responses outstanding",
                 $time, cycle_cnt, rsp_due_q.size());
        $display("FAIL");
        $finish;
    end

    initial begin : stim
        t_req w;
        t_rsp r;
        int   i;
        int   mode;
        bit   do_ins;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        @(posedge i_rst_n);
        @(negedge i_clk);

        for (i = 0; i < N_ROWS; i++) begin
            w.opcode      = dir_rows[i].op;
            w.value       = dir_rows[i].val;
            w.position    = dir_rows[i].pos;
            r.status      = dir_rows[i].st;
            r.entry_count = dir_rows[i].cnt;
            r.smallest    = dir_rows[i].sml;
            send_word(w, dir_rows[i].typed, r);
        end

        // Blocks of 100 words cycle through fill, mixed, drain, mixed so the
        // list hits both full and empty repeatedly.
        for (i = 0; i < N_RANDOM; i++) begin
            idle_ok = (i < N_RANDOM - QUIET_TAIL) && ((i / 100) % 5 != 4);
            mode = (i / 100) % 4;
            case (mode)
                0: do_ins = ($urandom_range(0, 99) < 85);
                2: do_ins = ($urandom_range(0, 99) < 15);
                default: do_ins = ($urandom_range(0, 1) == 0);
            endcase
            w.opcode   = do_ins ? OP_INSERT : OP_DELETE;
            w.value    = pick_value();
            w.position = pick_position();
            send_word(w, 1'b0, r);
        end
        req_if.valid = 1'b0;

        while (rsp_due_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d words: %0d inserts, %0d deletes, peak fill %0d of %0d.",
                 n_ins + n_del, n_ins, n_del, peak_fill, LIST_DEPTH);
        $display("Refused: %0d on full list, %0d on empty list, %0d on bad position.",
                 n_full, n_empty, n_badpos);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/sli_pkg.sv
rtl/sli_if.sv
rtl/sli_ctrl.sv
rtl/sli_dpath.sv
rtl/sorted_list_insert_delete_core.sv
rtl/sli_checker.sv
dv/tb_top.sv
